// File: sv/chd_pkg.sv
// ----------------------------------------------------------------------------
// chd_pkg - shared types and constants for the canonical Huffman bit decoder
// Phase and mode encodings, result kinds, register map and parameter defaults.
// ----------------------------------------------------------------------------
package chd_pkg;

	localparam int SYMBOL_BITS_DEF  = 9;
	localparam int MAX_SYMBOLS_DEF  = 512;
	localparam int MAX_CODE_LEN_DEF = 32;

	localparam int OUT_SYM_W = 9;
	localparam int KIND_W    = 3;
	localparam int CFG_W     = 9;
	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;

	// register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_NAME_END  = 2'd0;
	localparam logic [1:0] REG_NEXT_FILE = 2'd1;
	localparam logic [1:0] REG_ARCH_END  = 2'd2;

	localparam logic [CFG_W-1:0] NAME_END_RST  = 9'd256;
	localparam logic [CFG_W-1:0] NEXT_FILE_RST = 9'd257;
	localparam logic [CFG_W-1:0] ARCH_END_RST  = 9'd258;

	// front end: header parse, then code walk, then halt
	typedef enum logic [2:0] {
		PH_COUNT,
		PH_SYMS,
		PH_LENS,
		PH_DECODE,
		PH_HALT
	} phase_t;

	// back end: what the next decoded symbol means
	typedef enum logic [1:0] {
		MD_NAME,
		MD_BODY,
		MD_DONE
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		K_NAME_CHAR   = 3'd0,
		K_BODY_BYTE   = 3'd1,
		K_NAME_END    = 3'd2,
		K_NEXT_FILE   = 3'd3,
		K_ARCHIVE_END = 3'd4,
		K_ERROR       = 3'd5
	} kind_t;

	// per-bit event from the front end
	typedef struct packed {
		logic tbl_we;	// header symbol goes into the symbol table
		logic hit;	// code matched, table read at tbl_addr
		logic fail;	// header or code error
	} dec_ev_t;

endpackage

// File: sv/chd_decode.sv
// ----------------------------------------------------------------------------
// chd_decode - header parser and canonical code walker
// Consumes one bit per step: assembles header words, keeps per-length code
// counts, and tracks first code / base index while walking a code.
// ----------------------------------------------------------------------------
module chd_decode #(
	parameter int SYMBOL_BITS  = chd_pkg::SYMBOL_BITS_DEF,
	parameter int MAX_SYMBOLS  = chd_pkg::MAX_SYMBOLS_DEF,
	parameter int MAX_CODE_LEN = chd_pkg::MAX_CODE_LEN_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           active,
	input  logic                           step,
	input  logic                           bit_in,
	output chd_pkg::dec_ev_t               ev,
	output logic [$clog2(MAX_SYMBOLS)-1:0] tbl_addr,
	output logic [SYMBOL_BITS-1:0]         tbl_wdata
);

	localparam int WB_W  = $clog2(SYMBOL_BITS + 1);
	localparam int LI_W  = $clog2(MAX_CODE_LEN + 2);
	localparam int LA_W  = $clog2(MAX_CODE_LEN);
	localparam int ACC_W = SYMBOL_BITS + $clog2(MAX_CODE_LEN) + 1;
	localparam int FW    = MAX_CODE_LEN;
	localparam int TA_W  = $clog2(MAX_SYMBOLS);
	localparam int CW    = (FW > SYMBOL_BITS) ? FW : SYMBOL_BITS;
	localparam int SW    = CW + 1;

	localparam logic [31:0]     MAX_SYM_L = 32'(MAX_SYMBOLS);
	localparam logic [WB_W-1:0] WORD_LAST = WB_W'(SYMBOL_BITS - 1);
	localparam logic [LA_W-1:0] LEN_LAST  = LA_W'(MAX_CODE_LEN - 1);
	localparam logic [LI_W-1:0] LI_MAX    = LI_W'(MAX_CODE_LEN);
	localparam logic [LI_W-1:0] LI_ONE    = LI_W'(1);

	chd_pkg::phase_t phase_q, phase_d;

	logic [SYMBOL_BITS-1:0] wshift_q;
	logic [WB_W-1:0]        wbc_q;
	logic [SYMBOL_BITS-1:0] total_q;
	logic [ACC_W-1:0]       recv_q;
	logic [LI_W-1:0]        li_q;
	logic [SYMBOL_BITS-1:0] lc_q [MAX_CODE_LEN];
	logic [FW-1:0]          partial_q;
	logic [FW-1:0]          first_q;
	logic                   big_q;	// first code beyond any code of MAX_CODE_LEN bits
	logic [ACC_W-1:0]       base_q;
	logic [LA_W-1:0]        clen_q;

	// header word assembly
	logic [SYMBOL_BITS-1:0] wshift_n;
	logic                   word_done, in_hdr, hdr_word, cnt_too_big;
	logic [ACC_W-1:0]       recv_inc, recv_add;
	logic                   syms_done, lens_done, lens_over;
	logic [LI_W-1:0]        li_inc;

	// code walk
	logic                   dec;
	logic [FW-1:0]          cand, diff;
	logic                   cnt_ok, code_hit, off_ok, overlong;
	logic [SYMBOL_BITS-1:0] cnt;
	logic [ACC_W:0]         off;
	logic [SW-1:0]          sum;
	logic [SW:0]            shifted;

	assign wshift_n    = {wshift_q[SYMBOL_BITS-2:0], bit_in};
	assign word_done   = (wbc_q == WORD_LAST);
	assign in_hdr      = (phase_q == chd_pkg::PH_COUNT) || (phase_q == chd_pkg::PH_SYMS) ||
	                     (phase_q == chd_pkg::PH_LENS);
	assign hdr_word    = active && in_hdr && word_done;
	assign cnt_too_big = 32'(wshift_n) > MAX_SYM_L;
	assign recv_inc    = recv_q + ACC_W'(1);
	assign syms_done   = recv_inc >= ACC_W'(total_q);
	assign recv_add    = recv_q + ACC_W'(wshift_n);
	assign lens_done   = recv_add >= ACC_W'(total_q);
	assign li_inc      = li_q + LI_ONE;
	assign lens_over   = li_inc > LI_MAX;

	assign dec      = active && (phase_q == chd_pkg::PH_DECODE);
	assign cand     = {partial_q[FW-2:0], bit_in};
	// only lengths already received carry codes
	assign cnt_ok   = (LI_W'(clen_q) + LI_ONE) < li_q;
	assign cnt      = cnt_ok ? lc_q[clen_q] : '0;
	assign diff     = cand - first_q;
	assign code_hit = !big_q && (cand >= first_q) && (CW'(diff) < CW'(cnt));
	assign off      = {1'b0, base_q} + (ACC_W + 1)'(diff);
	assign off_ok   = off < (ACC_W + 1)'(total_q);
	assign overlong = (clen_q == LEN_LAST);
	assign sum      = SW'(first_q) + SW'(cnt);
	assign shifted  = {sum, 1'b0};

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			chd_pkg::PH_COUNT: begin
				if (hdr_word) begin
					if (cnt_too_big)
						phase_d = chd_pkg::PH_HALT;
					else if (wshift_n == '0)
						phase_d = chd_pkg::PH_DECODE;
					else
						phase_d = chd_pkg::PH_SYMS;
				end
			end
			chd_pkg::PH_SYMS: begin
				if (hdr_word && syms_done)
					phase_d = chd_pkg::PH_LENS;
			end
			chd_pkg::PH_LENS: begin
				if (hdr_word) begin
					if (lens_done)
						phase_d = chd_pkg::PH_DECODE;
					else if (lens_over)
						phase_d = chd_pkg::PH_HALT;
				end
			end
			chd_pkg::PH_DECODE: begin
				if (dec && ((code_hit && !off_ok) || (!code_hit && overlong)))
					phase_d = chd_pkg::PH_HALT;
			end
			default: phase_d = phase_q;
		endcase
	end

	// events and table port
	always_comb begin
		ev.tbl_we = hdr_word && (phase_q == chd_pkg::PH_SYMS);
		ev.hit    = dec && code_hit && off_ok;
		ev.fail   = (hdr_word && (phase_q == chd_pkg::PH_COUNT) && cnt_too_big) ||
		            (hdr_word && (phase_q == chd_pkg::PH_LENS) && !lens_done && lens_over) ||
		            (dec && code_hit && !off_ok) ||
		            (dec && !code_hit && overlong);
		tbl_addr  = (phase_q == chd_pkg::PH_SYMS) ? TA_W'(recv_q) : TA_W'(off);
		tbl_wdata = wshift_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= chd_pkg::PH_COUNT;
			wshift_q  <= '0;
			wbc_q     <= '0;
			total_q   <= '0;
			recv_q    <= '0;
			li_q      <= LI_ONE;
			partial_q <= '0;
			first_q   <= '0;
			big_q     <= 1'b0;
			base_q    <= '0;
			clen_q    <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			if (in_hdr) begin
				wshift_q <= word_done ? '0 : wshift_n;
				wbc_q    <= word_done ? '0 : wbc_q + WB_W'(1);
			end
			if (hdr_word) begin
				case (phase_q)
					chd_pkg::PH_COUNT: begin
						if (!cnt_too_big) begin
							total_q   <= wshift_n;
							recv_q    <= '0;
							li_q      <= LI_ONE;
							partial_q <= '0;
							first_q   <= '0;
							big_q     <= 1'b0;
							base_q    <= '0;
							clen_q    <= '0;
						end
					end
					chd_pkg::PH_SYMS: begin
						if (syms_done) begin
							recv_q <= '0;
							li_q   <= LI_ONE;
						end else begin
							recv_q <= recv_inc;
						end
					end
					chd_pkg::PH_LENS: begin
						recv_q <= recv_add;
						li_q   <= li_inc;
						if (lens_done) begin
							partial_q <= '0;
							first_q   <= '0;
							big_q     <= 1'b0;
							base_q    <= '0;
							clen_q    <= '0;
						end
					end
					default: ;
				endcase
			end
			if (dec) begin
				if (code_hit) begin
					partial_q <= '0;
					first_q   <= '0;
					big_q     <= 1'b0;
					base_q    <= '0;
					clen_q    <= '0;
				end else if (!overlong) begin
					base_q    <= base_q + ACC_W'(cnt);
					first_q   <= shifted[FW-1:0];
					big_q     <= big_q | (|shifted[SW:FW]);
					partial_q <= cand;
					clen_q    <= clen_q + LA_W'(1);
				end
			end
		end
	end

	// per-length code counts, written once per length during the header
	always_ff @(posedge clk) begin
		if (step && hdr_word && (phase_q == chd_pkg::PH_LENS))
			lc_q[LA_W'(li_q - LI_ONE)] <= wshift_n;
	end

endmodule

// File: sv/canonical_huffman_bit_decoder_core.sv
// ----------------------------------------------------------------------------
// canonical_huffman_bit_decoder_core - bit-serial canonical Huffman decoder
// Parses the code header from the bit stream, then decodes symbols and tags
// each one as name char, body byte, name end, next file, archive end or error.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready/bit_in): one archive bit per request,
//    header words MSB first. A bit can be taken every cycle while in_ready is high.
//  - Output channel (out_valid/out_ready/symbol/kind): zero or one request
//    per input bit. Header bits and code bits that do not finish a code
//    give nothing; a finished code gives symbol + kind, an error gives
//    symbol 0 with kind error.
//  - Path: a result passes the input register, the table read and the output
//    register after the edge that took the bit that completed it.
//  - Throughput: one bit per cycle while in_ready is high, set by the code
//    walk in chd_decode (first code, base index, count lookup per bit).
//  - Stall: when out_ready is low the output register holds; bits that
//    produce no result keep flowing, and in_ready drops only once a second
//    decoded symbol waits in s2 behind the held one and the bit in s1 gives another result.
//  - Reset (arst_n low): header parsing restarts, marker registers return
//    to 256/257/258. Symbol table and length counts need no clearing, the
//    header refills them before use.
//  - After archive end or an error every further bit is dropped until reset.
//  - APB registers at 0x0/0x4/0x8: name end, next file, archive end symbols.
// ----------------------------------------------------------------------------
module canonical_huffman_bit_decoder_core #(
	parameter int SYMBOL_BITS  = chd_pkg::SYMBOL_BITS_DEF,
	parameter int MAX_SYMBOLS  = chd_pkg::MAX_SYMBOLS_DEF,
	parameter int MAX_CODE_LEN = chd_pkg::MAX_CODE_LEN_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// bit input
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           bit_in,
	// symbol output
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [chd_pkg::OUT_SYM_W-1:0]  symbol,
	output logic [chd_pkg::KIND_W-1:0]     kind,
	// APB config
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [chd_pkg::APB_AW-1:0]     paddr,
	input  logic [chd_pkg::APB_DW-1:0]     pwdata,
	output logic [chd_pkg::APB_DW-1:0]     prdata,
	output logic                           pready
);

	localparam int TA_W  = $clog2(MAX_SYMBOLS);
	localparam int EXT_W = (SYMBOL_BITS > chd_pkg::OUT_SYM_W) ? SYMBOL_BITS
	                                                           : chd_pkg::OUT_SYM_W;

	// ---------------- config registers ----------------
	logic [chd_pkg::CFG_W-1:0] name_end_q, next_file_q, arch_end_q;
	logic                      cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_end_q  <= chd_pkg::NAME_END_RST;
			next_file_q <= chd_pkg::NEXT_FILE_RST;
			arch_end_q  <= chd_pkg::ARCH_END_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				chd_pkg::REG_NAME_END:  name_end_q  <= pwdata[chd_pkg::CFG_W-1:0];
				chd_pkg::REG_NEXT_FILE: next_file_q <= pwdata[chd_pkg::CFG_W-1:0];
				chd_pkg::REG_ARCH_END:  arch_end_q  <= pwdata[chd_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			chd_pkg::REG_NAME_END:  prdata = chd_pkg::APB_DW'(name_end_q);
			chd_pkg::REG_NEXT_FILE: prdata = chd_pkg::APB_DW'(next_file_q);
			chd_pkg::REG_ARCH_END:  prdata = chd_pkg::APB_DW'(arch_end_q);
			default:                prdata = '0;
		endcase
	end

	// ---------------- pipeline control ----------------
	// s1: input bit register, processed by the front end
	// s2: event + symbol table read data
	// out: result register
	logic                   valid_s1, bit_s1;
	logic                   valid_s2, fail_s2;
	logic                   out_take, s2_emit, s2_move, s2_free;
	logic                   s1_event, s1_move, s1_free;
	chd_pkg::dec_ev_t       ev;
	logic [TA_W-1:0]        tbl_addr;
	logic [SYMBOL_BITS-1:0] tbl_wdata;
	chd_pkg::mode_t         mode_q, mode_d;

	assign out_take = !out_valid || out_ready;
	// once done, s2 drains without producing anything
	assign s2_emit  = valid_s2 && (mode_q != chd_pkg::MD_DONE);
	assign s2_move  = valid_s2 && (out_take || !s2_emit);
	assign s2_free  = !valid_s2 || s2_move;
	// a bit that produces no event never waits on s2
	assign s1_event = ev.hit || ev.fail;
	assign s1_move  = valid_s1 && (s2_free || !s1_event);
	assign s1_free  = !valid_s1 || s1_move;
	assign in_ready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_free)
				valid_s1 <= in_valid;
			if (s2_free)
				valid_s2 <= s1_move && s1_event;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && in_valid)
			bit_s1 <= bit_in;
		if (s2_free)
			fail_s2 <= ev.fail;
	end

	chd_decode #(
		.SYMBOL_BITS  (SYMBOL_BITS),
		.MAX_SYMBOLS  (MAX_SYMBOLS),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.active    (valid_s1),
		.step      (s1_move),
		.bit_in    (bit_s1),
		.ev        (ev),
		.tbl_addr  (tbl_addr),
		.tbl_wdata (tbl_wdata)
	);

	// ---------------- symbol table ----------------
	// filled in canonical order from the header, read once per decoded code
	logic [SYMBOL_BITS-1:0] tbl_mem [MAX_SYMBOLS];
	logic [SYMBOL_BITS-1:0] rd_s2;

	always_ff @(posedge clk) begin
		if (s1_move && ev.tbl_we)
			tbl_mem[tbl_addr] <= tbl_wdata;
		if (s1_move && ev.hit)
			rd_s2 <= tbl_mem[tbl_addr];
	end

	// ---------------- symbol classification ----------------
	logic [EXT_W-1:0]              sym_ext;
	logic                          is_name_end, is_next_file, is_arch_end;
	chd_pkg::kind_t                kind_d, kind_q;
	logic [chd_pkg::OUT_SYM_W-1:0] sym_d, sym_q;

	assign sym_ext      = EXT_W'(rd_s2);
	assign is_name_end  = (sym_ext == EXT_W'(name_end_q));
	assign is_next_file = (sym_ext == EXT_W'(next_file_q));
	assign is_arch_end  = (sym_ext == EXT_W'(arch_end_q));

	// next mode
	always_comb begin
		mode_d = mode_q;
		if (fail_s2) begin
			mode_d = chd_pkg::MD_DONE;
		end else begin
			case (mode_q)
				chd_pkg::MD_NAME: begin
					if (is_name_end)
						mode_d = chd_pkg::MD_BODY;
				end
				chd_pkg::MD_BODY: begin
					// archive end wins over next file
					if (is_arch_end)
						mode_d = chd_pkg::MD_DONE;
					else if (is_next_file)
						mode_d = chd_pkg::MD_NAME;
				end
				default: mode_d = mode_q;
			endcase
		end
	end

	// result
	always_comb begin
		sym_d  = sym_ext[chd_pkg::OUT_SYM_W-1:0];
		kind_d = chd_pkg::K_ERROR;
		if (fail_s2) begin
			sym_d  = '0;
			kind_d = chd_pkg::K_ERROR;
		end else begin
			case (mode_q)
				chd_pkg::MD_NAME:
					kind_d = is_name_end ? chd_pkg::K_NAME_END : chd_pkg::K_NAME_CHAR;
				chd_pkg::MD_BODY: begin
					if (is_arch_end)
						kind_d = chd_pkg::K_ARCHIVE_END;
					else if (is_next_file)
						kind_d = chd_pkg::K_NEXT_FILE;
					else
						kind_d = chd_pkg::K_BODY_BYTE;
				end
				default: kind_d = chd_pkg::K_ERROR;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= chd_pkg::MD_NAME;
			out_valid <= 1'b0;
		end else begin
			if (s2_move && s2_emit) begin
				mode_q    <= mode_d;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move && s2_emit) begin
			sym_q  <= sym_d;
			kind_q <= kind_d;
		end
	end

	assign symbol = sym_q;
	assign kind   = kind_q;

endmodule
